[src/deq_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// deq_pkg: shared types and constants for the double-ended queue
// Holds the store geometry, the operation codes, the result layout and the
// circular index helper.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int DEPTH   = 1024;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int DATA_W  = 32;
  localparam int OP_W    = 3;
  localparam int COUNT_W = 11;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_QUERY      = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } state_e;

  typedef struct packed {
    logic [1:0]         pad;
    logic               overflow;
    logic [DATA_W-1:0]  back_value;
    logic [DATA_W-1:0]  front_value;
    logic               is_empty;
    logic [COUNT_W-1:0] element_count;
    logic [DATA_W-1:0]  popped_value;
    logic               popped_valid;
  } res_t;

  localparam int OUT_W = $bits(res_t);

  function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] pos,
                                                input logic [CNT_W-1:0] amt);
    logic [CNT_W:0] sum;
    sum = {{(CNT_W + 1 - IDX_W){1'b0}}, pos} + {1'b0, amt};
    if (sum >= (CNT_W + 1)'(DEPTH)) begin
      sum = sum - (CNT_W + 1)'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage
`default_nettype wire

[src/deq_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// deq_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module deq_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

[src/double_ended_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// double_ended_queue: bounded deque of 32-bit words in a circular RAM
// Push or pop at either end, or query; one result item per input item.
//
//   channel   dir  tdata                                   tuser
//   s_axis    in   [31:0] value                            [2:0] operation
//   m_axis    out  [0] popped_valid [32:1] popped_value    -
//                  [43:33] element_count [44] is_empty
//                  [76:45] front_value [108:77] back_value
//                  [109] overflow [111:110] zero
//
// Push, query and a pop that empties the queue or finds it empty answer in the
// next cycle. A pop that leaves one or more elements goes through ST_READ: the
// new front or back word is fetched through the RAM's registered read port.
// Front and back words are cached in registers; the RAM holds all elements.
// Reset empties the queue at once; RAM contents are not cleared.
// A full output register stalls input only until m_axis_tready is seen.
// ----------------------------------------------------------------------------
module double_ended_queue (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       s_axis_tvalid,
  output logic                            s_axis_tready,
  input  wire logic [deq_pkg::DATA_W-1:0] s_axis_tdata,   // [31:0] value
  input  wire logic [deq_pkg::OP_W-1:0]   s_axis_tuser,   // [2:0] operation
  output logic                            m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  output logic      [deq_pkg::OUT_W-1:0]  m_axis_tdata    // see table above
);

  import deq_pkg::*;

  state_e            state_q, state_d;
  logic [IDX_W-1:0]  head_q, head_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              out_valid_q, out_valid_d;
  logic              rd_front_q, rd_front_d;
  logic [DATA_W-1:0] front_q, front_d;
  logic [DATA_W-1:0] back_q, back_d;
  res_t              res_q, res_d;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic              ram_re;
  logic [IDX_W-1:0]  ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  logic              in_fire;
  logic              is_full;
  logic              is_empty_now;
  logic [IDX_W-1:0]  head_dec;

  assign s_axis_tready = (state_q == ST_IDLE) && (!out_valid_q || m_axis_tready);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign is_full       = (count_q == CNT_W'(DEPTH));
  assign is_empty_now  = (count_q == '0);
  assign head_dec      = (head_q == '0) ? IDX_W'(DEPTH - 1) : head_q - 1'b1;

  always_comb begin
    logic              pv;
    logic [DATA_W-1:0] pval;
    logic              ovf;
    logic              need_rd;
    pv          = 1'b0;
    pval        = '0;
    ovf         = 1'b0;
    need_rd     = 1'b0;
    state_d     = state_q;
    head_d      = head_q;
    count_d     = count_q;
    front_d     = front_q;
    back_d      = back_q;
    res_d       = res_q;
    rd_front_d  = rd_front_q;
    out_valid_d = out_valid_q;
    ram_we      = 1'b0;
    ram_waddr   = head_q;
    ram_re      = 1'b0;
    ram_raddr   = head_q;

    if (m_axis_tvalid && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          case (s_axis_tuser)
            OP_PUSH_FRONT: begin
              if (is_full) begin
                ovf = 1'b1;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = head_dec;
                head_d    = head_dec;
                count_d   = count_q + 1'b1;
                front_d   = s_axis_tdata;
                if (is_empty_now) begin
                  back_d = s_axis_tdata;
                end
              end
            end
            OP_PUSH_BACK: begin
              if (is_full) begin
                ovf = 1'b1;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = wrap_add(head_q, count_q);
                count_d   = count_q + 1'b1;
                back_d    = s_axis_tdata;
                if (is_empty_now) begin
                  front_d = s_axis_tdata;
                end
              end
            end
            OP_POP_FRONT: begin
              if (!is_empty_now) begin
                pv      = 1'b1;
                pval    = front_q;
                count_d = count_q - 1'b1;
                head_d  = wrap_add(head_q, CNT_W'(1));
                if (count_q > CNT_W'(1)) begin
                  ram_re     = 1'b1;
                  ram_raddr  = wrap_add(head_q, CNT_W'(1));
                  need_rd    = 1'b1;
                  rd_front_d = 1'b1;
                end
              end
            end
            OP_POP_BACK: begin
              if (!is_empty_now) begin
                pv      = 1'b1;
                pval    = back_q;
                count_d = count_q - 1'b1;
                if (count_q > CNT_W'(1)) begin
                  ram_re     = 1'b1;
                  ram_raddr  = wrap_add(head_q, count_q - CNT_W'(2));
                  need_rd    = 1'b1;
                  rd_front_d = 1'b0;
                end
              end
            end
            default: begin
            end
          endcase

          res_d.pad           = '0;
          res_d.popped_valid  = pv;
          res_d.popped_value  = pval;
          res_d.element_count = COUNT_W'(count_d);
          res_d.is_empty      = (count_d == '0);
          res_d.front_value   = (count_d == '0) ? '0 : front_d;
          res_d.back_value    = (count_d == '0) ? '0 : back_d;
          res_d.overflow      = ovf;

          if (need_rd) begin
            state_d = ST_READ;
          end else begin
            out_valid_d = 1'b1;
          end
        end
      end
      ST_READ: begin
        if (rd_front_q) begin
          front_d           = ram_rdata;
          res_d.front_value = ram_rdata;
        end else begin
          back_d           = ram_rdata;
          res_d.back_value = ram_rdata;
        end
        out_valid_d = 1'b1;
        state_d     = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      rd_front_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      rd_front_q  <= rd_front_d;
    end
  end

  always_ff @(posedge clk_i) begin
    front_q <= front_d;
    back_q  <= back_d;
    res_q   <= res_d;
  end

  deq_ram #(
    .Width(DATA_W),
    .Depth(DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(s_axis_tdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = res_q;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("element count exceeds store depth");

  a_read_no_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_READ |-> !m_axis_tvalid)
    else $error("output register busy while fetching from store");

  a_read_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_READ |=> state_q == ST_IDLE)
    else $error("store fetch did not finish in one cycle");

  a_overflow_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res_q.overflow |-> res_q.element_count == COUNT_W'(DEPTH))
    else $error("overflow reported while queue not full");

  a_pop_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && count_q > CNT_W'(1) &&
    (s_axis_tuser == OP_POP_FRONT || s_axis_tuser == OP_POP_BACK)
    |=> state_q == ST_READ)
    else $error("pop leaving elements did not fetch the new end word");
`endif

endmodule
`default_nettype wire
